/* sv/tes_pkg.sv */
package tes_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 32;
  localparam logic [30:0] FRAME_MAX = 31'h7FFF_FFFF;

  // input item selector
  localparam logic [1:0] ACT_QUEUE   = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_RESET   = 2'd2;

  // result kinds
  localparam logic [1:0] RK_ACK      = 2'd0;
  localparam logic [1:0] RK_DISPATCH = 2'd1;
  localparam logic [1:0] RK_FINISH   = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_LATE = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [30:0] etime;
    logic [3:0]  kind;
    logic [7:0]  channel;
    logic [7:0]  data1;
    logic [15:0] data2;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_cmd_t;

endpackage

/* sv/tes_cell.sv */
module tes_cell #(
  parameter int QUEUE_DEPTH = tes_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int IDX = 0,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  tes_pkg::cell_cmd_t cmd,
  input  logic [CntW-1:0]    count,
  input  tes_pkg::entry_t    new_ent,
  input  tes_pkg::entry_t    left_ent,
  input  logic               left_gt,
  input  tes_pkg::entry_t    right_ent,
  output tes_pkg::entry_t    ent,
  output logic               gt
);
  import tes_pkg::*;

  logic occupied;
  logic at_tail;

  assign occupied = CntW'(IDX) < count;
  assign at_tail  = CntW'(IDX) == count;
  // strict compare keeps equal times in arrival order
  assign gt       = occupied && (ent.etime > new_ent.etime);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (left_gt) begin
        ent <= left_ent;
      end else if (gt || at_tail) begin
        ent <= new_ent;
      end
    end else if (cmd.pop) begin
      ent <= right_ent;
    end
  end

endmodule

/* sv/timed_event_scheduler.sv */
// A queue word is registered on acceptance; in the exec state, once the output
// is free, its acknowledge is loaded into the output register. An advance word
// gives one dispatch per cycle while the output is free, then the finish word;
// the cell chain pops the head with each dispatch. New words are taken only
// when idle, after the last word is done; a stalled output holds the chain.
// Reset (rst, synchronous) empties the queue and zeroes the frame counter.
module timed_event_scheduler #(
  parameter int QUEUE_DEPTH = tes_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // event_time[30:0], msg_kind[34:31], channel[42:35], data1[50:43],
  // data2[66:51], frame_count[82:67], zero fill above
  input  logic [87:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], out_kind[5:2], out_channel[13:6], out_data1[21:14],
  // out_data2[37:22], dispatch_frame[68:38], zero fill above
  output logic [71:0] m_tdata,
  // result_kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import tes_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic [1:0]      it_action;
  entry_t          it_ent;
  logic [15:0]     it_fc;
  logic [CntW-1:0] count;
  logic [30:0]     frame_now;
  logic [30:0]     batch_end;
  logic [31:0]     end_sum;

  entry_t    ent_q [QUEUE_DEPTH];
  logic      gt_q  [QUEUE_DEPTH];
  cell_cmd_t cmd;

  logic   out_free, late, full, head_due;
  logic   out_load, finish;
  logic   o_last;
  logic [1:0] o_kind, o_status;
  entry_t o_ent;

  assign out_free = !m_tvalid || m_tready;
  assign late     = it_ent.etime < frame_now;
  assign full     = count >= CntW'(QUEUE_DEPTH);
  assign head_due = (count != '0) && (ent_q[0].etime < batch_end);
  assign end_sum  = {1'b0, frame_now} + {16'd0, it_fc};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (it_action == ACT_ADVANCE) begin
          state_next = ST_DRAIN;
        end else if (it_action != ACT_QUEUE || out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free && !head_due) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    out_load = 1'b0;
    finish   = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EXEC: begin
        if (it_action == ACT_QUEUE && out_free) begin
          out_load = 1'b1;
          cmd.ins  = !late && !full;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          cmd.pop  = head_due;
          finish   = !head_due;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      frame_now <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC && it_action == ACT_RESET) begin
        count     <= '0;
        frame_now <= '0;
      end else if (cmd.ins) begin
        count <= count + CntW'(1);
      end else if (cmd.pop) begin
        count <= count - CntW'(1);
      end
      if (finish) frame_now <= batch_end;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      it_action     <= s_tuser;
      it_ent.etime  <= s_tdata[30:0];
      it_ent.kind   <= s_tdata[34:31];
      it_ent.channel <= s_tdata[42:35];
      it_ent.data1  <= s_tdata[50:43];
      it_ent.data2  <= s_tdata[66:51];
      it_fc         <= s_tdata[82:67];
    end
    // saturate the batch end at the largest frame
    if (state == ST_EXEC) begin
      batch_end <= end_sum[31] ? FRAME_MAX : end_sum[30:0];
    end
    if (out_load) begin
      if (state == ST_EXEC) begin
        o_kind   <= RK_ACK;
        o_status <= late ? STAT_LATE : (full ? STAT_FULL : STAT_OK);
        o_ent    <= '0;
        o_last   <= 1'b1;
      end else if (head_due) begin
        o_kind   <= RK_DISPATCH;
        o_status <= STAT_OK;
        o_ent    <= ent_q[0];
        o_last   <= 1'b0;
      end else begin
        o_kind       <= RK_FINISH;
        o_status     <= STAT_OK;
        // frame in the time field, payload zero
        o_ent        <= entry_t'({batch_end, 36'd0});
        o_last       <= 1'b1;
      end
    end
  end

  assign m_tdata = {3'd0, o_ent.etime, o_ent.data2, o_ent.data1, o_ent.channel,
                    o_ent.kind, o_status};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  // sorted chain: insert shifts later entries right, pop shifts all left
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_gt;
    if (i == 0) begin : g_head
      assign left_ent = it_ent;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_ent = ent_q[i-1];
      assign left_gt  = gt_q[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = ent_q[i];
    end else begin : g_mid
      assign right_ent = ent_q[i+1];
    end
    tes_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count),
      .new_ent  (it_ent),
      .left_ent (left_ent),
      .left_gt  (left_gt),
      .right_ent(right_ent),
      .ent      (ent_q[i]),
      .gt       (gt_q[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CntW'(1))
    else $error("insert did not grow the queue");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - CntW'(1))
    else $error("pop did not shrink the queue");

  a_head_not_late: assert property (@(posedge clk) disable iff (rst)
    (count != '0 && state == ST_IDLE) |-> ent_q[0].etime >= frame_now)
    else $error("queued event earlier than current frame");

  a_no_load_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && cmd.pop))
    else $error("insert and pop in one cycle");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tes_pkg::*;

  localparam int QDEPTH      = DEFAULT_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_WORDS = 140;
  localparam int HIGH_ADVANCES = 8;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  action;
    logic [30:0] etime;
    logic [3:0]  kind;
    logic [7:0]  channel;
    logic [7:0]  data1;
    logic [15:0] data2;
    logic [15:0] fcount;
    int          phase;
    bit          drain_first;
  } sched_word_t;

  typedef struct {
    logic [1:0]  rkind;
    logic [1:0]  status;
    logic [3:0]  kind;
    logic [7:0]  channel;
    logic [7:0]  data1;
    logic [15:0] data2;
    logic [30:0] frame;
    logic        is_last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  sched_word_t   pending_words[$];
  sched_result_t expected_results[$];
  sched_word_t   cur_word;
  int            rx_stall_pct = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // scheduler shadow state
  entry_t      sched_q[QDEPTH];
  int          sched_count = 0;
  logic [30:0] sched_frame = '0;

  // stimulus generation state
  logic [30:0] gen_frame = '0;
  int          gen_phase = 0;
  bit          drain_next = 1'b0;

  timed_event_scheduler #(.QUEUE_DEPTH(QDEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int send_idle_pct(input int phase);
    return (phase == 0) ? 25 : (phase == 1) ? 78 : 0;
  endfunction

  function automatic int recv_stall_pct(input int phase);
    return (phase == 0) ? 78 : (phase == 1) ? 25 : 0;
  endfunction

  function automatic logic [30:0] frame_plus(input logic [30:0] f, input longint unsigned d);
    longint unsigned s;
    s = longint'(f) + d;
    return (s > longint'(FRAME_MAX)) ? FRAME_MAX : s[30:0];
  endfunction

  function automatic sched_result_t make_result(input logic [1:0] rk, input logic [1:0] st,
                                                input entry_t e, input logic [30:0] frame,
                                                input logic lst);
    sched_result_t r;
    r.rkind   = rk;
    r.status  = st;
    r.kind    = e.kind;
    r.channel = e.channel;
    r.data1   = e.data1;
    r.data2   = e.data2;
    r.frame   = frame;
    r.is_last = lst;
    return r;
  endfunction

  task automatic expect_result(input sched_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // work out the results of one accepted word and update the shadow queue
  task automatic schedule_word(input sched_word_t w);
    logic [31:0] batch_end;
    entry_t      e;
    int          pos;
    int          n;
    int          i;
    e = '{etime: w.etime, kind: w.kind, channel: w.channel, data1: w.data1, data2: w.data2};
    case (w.action)
      ACT_QUEUE: begin
        if (w.etime < sched_frame) begin
          expect_result(make_result(RK_ACK, STAT_LATE, '0, '0, 1'b1));
        end else if (sched_count >= QDEPTH) begin
          expect_result(make_result(RK_ACK, STAT_FULL, '0, '0, 1'b1));
        end else begin
          // insert behind equal times so ties keep arrival order
          pos = sched_count;
          while (pos > 0 && sched_q[pos - 1].etime > w.etime) begin
            sched_q[pos] = sched_q[pos - 1];
            pos--;
          end
          sched_q[pos] = e;
          sched_count++;
          expect_result(make_result(RK_ACK, STAT_OK, '0, '0, 1'b1));
        end
      end
      ACT_ADVANCE: begin
        batch_end = {1'b0, sched_frame} + {16'd0, w.fcount};
        if (batch_end > {1'b0, FRAME_MAX}) batch_end = {1'b0, FRAME_MAX};
        n = 0;
        while (n < sched_count && sched_q[n].etime < batch_end[30:0]) begin
          expect_result(make_result(RK_DISPATCH, STAT_OK, sched_q[n],
                                    sched_q[n].etime, 1'b0));
          n++;
        end
        for (i = 0; i + n < sched_count; i++) sched_q[i] = sched_q[i + n];
        sched_count -= n;
        sched_frame = batch_end[30:0];
        expect_result(make_result(RK_FINISH, STAT_OK, '0, sched_frame, 1'b1));
      end
      ACT_RESET: begin
        sched_count = 0;
        sched_frame = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) schedule_word(cur_word);
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct(pending_words[0].phase) &&
            !(pending_words[0].drain_first && expected_results.size() != 0)) begin
          cur_word = pending_words[0];
          pending_words.delete(0);
          s_tvalid <= 1'b1;
          s_tdata  <= {5'd0, cur_word.fcount, cur_word.data2, cur_word.data1,
                       cur_word.channel, cur_word.kind, cur_word.etime};
          s_tuser  <= cur_word.action;
          rx_stall_pct <= recv_stall_pct(cur_word.phase);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word, kind", m_tuser, 0);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        check_field("result_kind", m_tuser, want.rkind);
        check_field("status", m_tdata[1:0], want.status);
        check_field("out_kind", m_tdata[5:2], want.kind);
        check_field("out_channel", m_tdata[13:6], want.channel);
        check_field("out_data1", m_tdata[21:14], want.data1);
        check_field("out_data2", m_tdata[37:22], want.data2);
        check_field("dispatch_frame", m_tdata[68:38], want.frame);
        check_field("tdata fill", m_tdata[71:69], 0);
        check_field("tlast", m_tlast, want.is_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic sched_word_t rand_word(input logic [1:0] action);
    sched_word_t w;
    w.action  = action;
    w.etime   = 31'($urandom);
    w.kind    = 4'($urandom);
    w.channel = 8'($urandom);
    w.data1   = 8'($urandom);
    w.data2   = 16'($urandom);
    w.fcount  = 16'($urandom);
    w.phase   = gen_phase;
    w.drain_first = 1'b0;
    return w;
  endfunction

  // queue a word and track the frame counter it leaves behind
  task automatic add_word(input sched_word_t w);
    w.phase = gen_phase;
    w.drain_first = drain_next;
    drain_next = 1'b0;
    if (w.action == ACT_ADVANCE) gen_frame = frame_plus(gen_frame, w.fcount);
    else if (w.action == ACT_RESET) gen_frame = '0;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_queue(input logic [30:0] t);
    sched_word_t w;
    w = rand_word(ACT_QUEUE);
    w.etime = t;
    add_word(w);
  endtask

  task automatic add_advance(input logic [15:0] fc);
    sched_word_t w;
    w = rand_word(ACT_ADVANCE);
    w.fcount = fc;
    add_word(w);
  endtask

  task automatic add_late();
    int unsigned back;
    back = (gen_frame < 300) ? gen_frame : 300;
    add_queue(31'(gen_frame - $urandom_range(1, back)));
  endtask

  initial begin
    sched_word_t w;
    int          random_count;
    int          roll;
    int          i;

    // directed: field extremes, ties, late and ignored words
    gen_phase = 0;
    w = rand_word(ACT_QUEUE);
    w.etime = 31'd5; w.kind = '0; w.channel = '0; w.data1 = '0; w.data2 = '0; w.fcount = '0;
    add_word(w);
    w = rand_word(ACT_QUEUE);
    w.etime = 31'd5; w.kind = 4'hF; w.channel = 8'hFF; w.data1 = 8'hFF; w.data2 = 16'hFFFF;
    w.fcount = 16'hFFFF;
    add_word(w);
    w = rand_word(ACT_QUEUE);
    w.etime = 31'd2; w.kind = 4'd8;
    add_word(w);
    add_queue(FRAME_MAX);
    add_word(rand_word(ACT_UNUSED));
    add_advance(16'd0);
    add_advance(16'd6);
    add_queue(31'd5);
    add_queue(31'd6);
    add_advance(16'hFFFF);
    add_word(rand_word(ACT_RESET));
    add_advance(16'd1);
    add_queue(31'd0);
    add_queue(31'd1);
    add_advance(16'd2);

    // random: mostly well-formed traffic near the current frame
    random_count = 0;
    while (random_count < RANDOM_WORDS) begin
      if (gen_phase == 0 && random_count >= RANDOM_WORDS / 2) begin
        gen_phase = 1;
        drain_next = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // fill to full, then a late word while full
        add_advance(16'($urandom_range(1, 50)));
        for (i = 0; i < QDEPTH + 2; i++) add_queue(frame_plus(gen_frame, $urandom_range(0, 100)));
        add_late();
        random_count += QDEPTH + 4;
      end else if (roll < 50) begin
        add_queue(frame_plus(gen_frame, $urandom_range(0, 400)));
        random_count++;
      end else if (roll < 56) begin
        if (gen_frame != 0) add_late();
        else add_queue(frame_plus(gen_frame, $urandom_range(0, 20)));
        random_count++;
      end else if (roll < 61) begin
        add_word(rand_word(ACT_QUEUE));
        random_count++;
      end else if (roll < 82) begin
        add_advance(16'($urandom_range(0, 300)));
        random_count++;
      end else if (roll < 86) begin
        add_advance(16'd0);
        random_count++;
      end else if (roll < 91) begin
        add_advance(16'($urandom));
        random_count++;
      end else if (roll < 96) begin
        add_word(rand_word(ACT_RESET));
        random_count++;
      end else begin
        add_word(rand_word(ACT_UNUSED));
      end
    end

    // events spread over the high range, top frame values, and long advances
    gen_phase = 2;
    drain_next = 1'b1;
    add_word(rand_word(ACT_RESET));
    for (i = 0; i < 12; i++) add_queue({1'b1, 30'($urandom)});
    for (i = 0; i < 6; i++) add_word(rand_word(ACT_QUEUE));
    add_queue(FRAME_MAX);
    add_queue(FRAME_MAX - 31'd1);
    add_queue(FRAME_MAX - 31'd1);
    for (i = 0; i < HIGH_ADVANCES; i++) begin
      if (i == HIGH_ADVANCES / 2) add_queue(frame_plus(gen_frame, $urandom_range(0, 200000)));
      add_advance(16'hFFFF);
    end
    add_advance(16'd0);
    add_advance(16'hFFFF);
    add_queue(FRAME_MAX - 31'd1);
    add_queue(FRAME_MAX);
    add_advance(16'd100);
    add_word(rand_word(ACT_RESET));
    add_queue(31'd0);
    add_advance(16'd1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results never seen, count", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
